FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the process window table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed: condition does not hold");

// Checks that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication does not hold");

// Checks that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication does not hold");

`endif

FILE: src/pmb_pkg.sv
// Package with the shared types and constants of the process window table.
`timescale 1ns / 1ps

package pmb_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	typedef enum logic [1:0] {
		MODE_INIT    = 2'd0,
		MODE_CREATE  = 2'd1,
		MODE_DESTROY = 2'd2,
		MODE_CHECK   = 2'd3
	} pmb_mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_INIT  = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} pmb_status_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] pid;
		logic [63:0] base;
		logic [63:0] limit;
	} pmb_entry_t;

	localparam int ENTRY_W = $bits(pmb_entry_t);

endpackage

FILE: src/pmb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/pid_memory_bounds_table_core.sv
// Top level of the process memory window table with its scan sequencer.
//
// Usage: an operation word (mode, process_id, window_base, window_limit,
// access_address) is taken at a rising edge where start is high and busy is
// low. Exactly one result word (status, access_allowed) follows, shown for a
// single cycle while done is high; the receiver cannot stall it, so it must
// capture the word in that cycle.
// Create, destroy and check walk the whole table through the one read port of
// the entry RAM, one entry per cycle. Create and destroy raise done from the
// decide state after the scan, as does check of a process without an entry.
// Check of a process with an entry goes on to the base test, and to the limit
// test only when the address does not lie below the base, since one shared
// 64-bit comparator tests the base and then the limit. Init rewrites every
// entry, one per cycle, and raises done at the end of that pass. Create before
// init skips the scan and raises done from the decide state.
// busy is high for the whole operation, so at most one word is in flight;
// a new word may be given in the cycle where done is high.
// After reset is released, a clearing pass writes every entry to empty while
// busy stays high; no result is produced for it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pid_memory_bounds_table_core import pmb_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] process_id,
	input  logic [63:0] window_base,
	input  logic [63:0] window_limit,
	input  logic [63:0] access_address,
	output logic        done,
	output logic [2:0]  status,
	output logic        access_allowed
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [5:0] {
		S_CLEAR     = 6'b000001,
		S_IDLE      = 6'b000010,
		S_SCAN      = 6'b000100,
		S_DECIDE    = 6'b001000,
		S_CHK_BASE  = 6'b010000,
		S_CHK_LIMIT = 6'b100000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  scan_q;
	logic              init_resp_q;
	logic              ready_q;
	logic              done_q;
	pmb_status_t       status_q;
	logic              allowed_q;
	logic              found_q;
	logic              free_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;

	pmb_mode_t         mode_q;
	logic [31:0]       pid_q;
	logic [63:0]       base_q;
	logic [63:0]       limit_q;
	logic [63:0]       addr_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [63:0]       match_base_q;
	logic [63:0]       match_limit_q;

	logic              accept;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	pmb_entry_t        ram_wentry;
	logic [ENTRY_W-1:0] ram_rdata;
	pmb_entry_t        rd_entry;
	logic              hit;
	logic              empty_slot;
	logic [63:0]       cmp_b;
	logic              below;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign rd_entry = pmb_entry_t'(ram_rdata);
	assign hit = vld_s1 && rd_entry.valid && (rd_entry.pid == pid_q);
	assign empty_slot = vld_s1 && !rd_entry.valid;

	// The shared comparator tests the address against the base, then the limit.
	assign cmp_b = (state_q == S_CHK_BASE) ? match_base_q : match_limit_q;
	assign below = addr_q < cmp_b;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = match_idx_q;
		ram_wentry = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = (scan_q != LAST_CNT);
				ram_waddr = scan_q[IDX_W-1:0];
			end
			S_DECIDE: begin
				if (mode_q == MODE_CREATE && ready_q && !found_q && free_q) begin
					ram_we = 1'b1;
					ram_waddr = free_idx_q;
					ram_wentry.valid = 1'b1;
					ram_wentry.pid = pid_q;
					ram_wentry.base = base_q;
					ram_wentry.limit = limit_q;
				end else if (mode_q == MODE_DESTROY && found_q) begin
					ram_we = 1'b1;
					ram_waddr = match_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	pmb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES),
		.AW(IDX_W)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			scan_q <= '0;
			init_resp_q <= 1'b0;
			ready_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			allowed_q <= 1'b0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (scan_q != LAST_CNT) begin
						scan_q <= scan_q + CNT_W'(1);
					end else begin
						state_q <= S_IDLE;
						if (init_resp_q) begin
							ready_q <= 1'b1;
							done_q <= 1'b1;
							status_q <= ST_OK;
							allowed_q <= 1'b0;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						scan_q <= '0;
						vld_s1 <= 1'b0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						if (pmb_mode_t'(mode) == MODE_INIT) begin
							state_q <= S_CLEAR;
							init_resp_q <= 1'b1;
						end else if (pmb_mode_t'(mode) == MODE_CREATE && !ready_q) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q != LAST_CNT) begin
						scan_q <= scan_q + CNT_W'(1);
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (empty_slot) begin
						free_q <= 1'b1;
					end
					if (scan_q == LAST_CNT && !vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					allowed_q <= 1'b0;
					status_q <= ST_OK;
					unique case (mode_q)
						MODE_CREATE: begin
							if (!ready_q) begin
								status_q <= ST_NOT_INIT;
							end else if (found_q) begin
								status_q <= ST_PRESENT;
							end else if (!free_q) begin
								status_q <= ST_FULL;
							end
						end
						MODE_DESTROY: begin
							if (!found_q) begin
								status_q <= ST_NOT_FOUND;
							end
						end
						MODE_CHECK: begin
							if (found_q) begin
								state_q <= S_CHK_BASE;
								done_q <= 1'b0;
							end else begin
								allowed_q <= 1'b1;
							end
						end
						MODE_INIT: begin
						end
					endcase
				end
				S_CHK_BASE: begin
					if (below) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						status_q <= ST_OK;
						allowed_q <= 1'b0;
					end else begin
						state_q <= S_CHK_LIMIT;
					end
				end
				S_CHK_LIMIT: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					status_q <= ST_OK;
					allowed_q <= below;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= pmb_mode_t'(mode);
			pid_q <= process_id;
			base_q <= window_base;
			limit_q <= window_limit;
			addr_q <= access_address;
		end
		idx_s1 <= scan_q[IDX_W-1:0];
		if (hit && !found_q) begin
			match_idx_q <= idx_s1;
			match_base_q <= rd_entry.base;
			match_limit_q <= rd_entry.limit;
		end
		if (empty_slot && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign access_allowed = allowed_q;

	`ASSERT_IMPLIES(a_done_when_idle, clk, arst_n, done_q, !busy)
	`ASSERT_NEXT(a_accept_makes_busy, clk, arst_n, accept, busy)
	`ASSERT_IMPLIES(a_write_only_busy, clk, arst_n, ram_we, busy)
	`ASSERT_IMPLIES(a_allowed_only_check, clk, arst_n, done_q && allowed_q,
		mode_q == MODE_CHECK)
	`ASSERT_IMPLIES(a_scan_in_range, clk, arst_n, state_q == S_SCAN, scan_q <= LAST_CNT)

endmodule
